// File: design/idll_pkg.sv
`default_nettype none
package idll_pkg;
	localparam int CAPACITY_DEF   = 16;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int OP_W           = 3;
	localparam int STATUS_W       = 2;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_INSERT     = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd4;
	localparam logic [OP_W-1:0] OP_ERASE      = 3'd5;
	localparam logic [OP_W-1:0] OP_READ       = 3'd6;
	localparam logic [OP_W-1:0] OP_WRITE      = 3'd7;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;
endpackage
`default_nettype wire

// File: design/idll_if.sv
`default_nettype none
interface idll_in_if #(
	parameter int POS_W  = 5,
	parameter int DATA_W = 32
);
	logic                        valid;
	logic                        ready;
	logic [idll_pkg::OP_W-1:0]   opcode;
	logic [POS_W-1:0]            position;
	logic [DATA_W-1:0]           data_in;

	modport source(output valid, opcode, position, data_in, input ready);
	modport sink(input valid, opcode, position, data_in, output ready);
endinterface

interface idll_out_if #(
	parameter int CNT_W  = 5,
	parameter int DATA_W = 32
);
	logic                          valid;
	logic                          ready;
	logic [idll_pkg::STATUS_W-1:0] status;
	logic [CNT_W-1:0]              count;
	logic [DATA_W-1:0]             data_out;

	modport source(output valid, status, count, data_out, input ready);
	modport sink(input valid, status, count, data_out, output ready);
endinterface
`default_nettype wire

// File: design/idll_ram.sv
`default_nettype none
module idll_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: design/indexed_doubly_linked_list.sv
`default_nettype none
// Doubly linked list engine over CAPACITY nodes held in four single-port-write RAMs
// (values, next links, prev links, free node stack). One request is handled at a
// time and returns one response with status, element count after the operation and
// the read or removed value. A rejected request goes straight to the output
// state; push, pop and end-position insert, erase and read pass through the walk
// and node states, write ends in the walk state, and an insert in the middle adds
// a state for its second link update; a positional operation walks links from the
// nearer end, following at most CAPACITY/2 links. A new request is taken while the
// previous response still waits on rsp.
module indexed_doubly_linked_list #(
	parameter int CAPACITY   = idll_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = idll_pkg::DATA_WIDTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	idll_in_if.sink   req,
	idll_out_if.source rsp
);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_WALK = 3'd1;
	localparam logic [2:0] S_NODE = 3'd2;
	localparam logic [2:0] S_INS2 = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0]                        state_q;
	logic [idll_pkg::OP_W-1:0]         act_q;
	logic [DATA_WIDTH-1:0]             data_q;
	logic [IW-1:0]                     node_q, n_q, p_q, head_q, tail_q;
	logic [CW-1:0]                     steps_q, count_q, fresh_q, sp_q;
	logic                              dir_q, pend_q;
	logic [idll_pkg::STATUS_W-1:0]     res_status_q, out_status_q;
	logic [DATA_WIDTH-1:0]             res_data_q, out_data_q;
	logic [CW-1:0]                     out_count_q;
	logic                              out_valid_q;

	logic                  val_we, nxt_we, prv_we, stk_we;
	logic [IW-1:0]         val_wa, nxt_wa, prv_wa, stk_wa;
	logic [DATA_WIDTH-1:0] val_wd, val_rd;
	logic [IW-1:0]         nxt_wd, prv_wd, stk_wd, nxt_rd, prv_rd, stk_rd;
	logic [IW-1:0]         cur, n_new, stk_ra;
	logic                  fresh_ok, accept, out_load;
	logic [CW-1:0]         pos, count_m1;

	idll_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_val (
		.clk(clk), .we(val_we), .waddr(val_wa), .wdata(val_wd), .raddr(cur), .rdata(val_rd)
	);
	idll_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_nxt (
		.clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd), .raddr(cur), .rdata(nxt_rd)
	);
	idll_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_prv (
		.clk(clk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd), .raddr(cur), .rdata(prv_rd)
	);
	idll_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_stk (
		.clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd), .raddr(stk_ra), .rdata(stk_rd)
	);

	assign req.ready    = (state_q == S_IDLE);
	assign accept       = req.valid && req.ready;
	assign pos          = req.position;
	assign count_m1     = count_q - CW'(1);
	assign cur          = pend_q ? (dir_q ? nxt_rd : prv_rd) : node_q;
	assign stk_ra       = IW'(sp_q - CW'(1));
	assign fresh_ok     = (fresh_q != CW'(CAPACITY));
	assign n_new        = fresh_ok ? fresh_q[IW-1:0] : stk_rd;
	assign out_load     = (state_q == S_OUT) && (!out_valid_q || rsp.ready);
	assign rsp.valid    = out_valid_q;
	assign rsp.status   = out_status_q;
	assign rsp.count    = out_count_q;
	assign rsp.data_out = out_data_q;

	always_comb begin
		val_we = 1'b0; val_wa = node_q; val_wd = data_q;
		nxt_we = 1'b0; nxt_wa = n_new;  nxt_wd = node_q;
		prv_we = 1'b0; prv_wa = n_new;  prv_wd = node_q;
		stk_we = 1'b0; stk_wa = sp_q[IW-1:0]; stk_wd = node_q;
		unique case (state_q)
			S_WALK: begin
				if (steps_q == '0 && act_q == idll_pkg::OP_WRITE) begin
					val_we = 1'b1;
					val_wa = cur;
				end
			end
			S_NODE: begin
				unique case (act_q)
					idll_pkg::OP_PUSH_FRONT: begin
						val_we = 1'b1; val_wa = n_new;
						nxt_we = 1'b1; nxt_wa = n_new; nxt_wd = head_q;
						prv_we = (count_q != '0); prv_wa = head_q; prv_wd = n_new;
					end
					idll_pkg::OP_PUSH_BACK: begin
						val_we = 1'b1; val_wa = n_new;
						prv_we = 1'b1; prv_wa = n_new; prv_wd = tail_q;
						nxt_we = (count_q != '0); nxt_wa = tail_q; nxt_wd = n_new;
					end
					idll_pkg::OP_INSERT: begin
						val_we = 1'b1; val_wa = n_new;
						nxt_we = 1'b1; nxt_wa = n_new; nxt_wd = node_q;
						prv_we = 1'b1; prv_wa = node_q; prv_wd = n_new;
					end
					idll_pkg::OP_POP_FRONT, idll_pkg::OP_POP_BACK: begin
						stk_we = 1'b1;
					end
					idll_pkg::OP_ERASE: begin
						stk_we = 1'b1;
						nxt_we = 1'b1; nxt_wa = prv_rd; nxt_wd = nxt_rd;
						prv_we = 1'b1; prv_wa = nxt_rd; prv_wd = prv_rd;
					end
					default: begin
					end
				endcase
			end
			S_INS2: begin
				prv_we = 1'b1; prv_wa = n_q; prv_wd = p_q;
				nxt_we = 1'b1; nxt_wa = p_q; nxt_wd = n_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			fresh_q     <= '0;
			sp_q        <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						data_q       <= req.data_in;
						res_status_q <= idll_pkg::ST_OK;
						res_data_q   <= '0;
						pend_q       <= 1'b0;
						steps_q      <= '0;
						act_q        <= req.opcode;
						node_q       <= head_q;
						dir_q        <= 1'b1;
						state_q      <= S_WALK;
						unique case (req.opcode)
							idll_pkg::OP_PUSH_FRONT, idll_pkg::OP_PUSH_BACK: begin
								if (count_q == CW'(CAPACITY)) begin
									res_status_q <= idll_pkg::ST_FULL;
									state_q      <= S_OUT;
								end
							end
							idll_pkg::OP_INSERT: begin
								priority if (pos > count_q) begin
									res_status_q <= idll_pkg::ST_RANGE;
									state_q      <= S_OUT;
								end else if (count_q == CW'(CAPACITY)) begin
									res_status_q <= idll_pkg::ST_FULL;
									state_q      <= S_OUT;
								end else if (pos == '0) begin
									act_q <= idll_pkg::OP_PUSH_FRONT;
								end else if (pos == count_q) begin
									act_q <= idll_pkg::OP_PUSH_BACK;
								end else if (pos < (count_q >> 1)) begin
									steps_q <= pos;
								end else begin
									node_q  <= tail_q;
									dir_q   <= 1'b0;
									steps_q <= count_m1 - pos;
								end
							end
							idll_pkg::OP_POP_FRONT, idll_pkg::OP_POP_BACK: begin
								if (count_q == '0) begin
									res_status_q <= idll_pkg::ST_EMPTY;
									state_q      <= S_OUT;
								end
								if (req.opcode == idll_pkg::OP_POP_BACK) begin
									node_q <= tail_q;
								end
							end
							default: begin
								priority if (count_q == '0) begin
									res_status_q <= idll_pkg::ST_EMPTY;
									state_q      <= S_OUT;
								end else if (pos >= count_q) begin
									res_status_q <= idll_pkg::ST_RANGE;
									state_q      <= S_OUT;
								end else if (req.opcode == idll_pkg::OP_ERASE && pos == '0) begin
									act_q <= idll_pkg::OP_POP_FRONT;
								end else if (req.opcode == idll_pkg::OP_ERASE
										&& pos == count_m1) begin
									act_q  <= idll_pkg::OP_POP_BACK;
									node_q <= tail_q;
								end else if (pos < (count_q >> 1)) begin
									steps_q <= pos;
								end else begin
									node_q  <= tail_q;
									dir_q   <= 1'b0;
									steps_q <= count_m1 - pos;
								end
							end
						endcase
					end
				end
				S_WALK: begin
					node_q <= cur;
					if (steps_q != '0) begin
						pend_q  <= 1'b1;
						steps_q <= steps_q - CW'(1);
					end else begin
						pend_q  <= 1'b0;
						state_q <= (act_q == idll_pkg::OP_WRITE) ? S_OUT : S_NODE;
					end
				end
				S_NODE: begin
					state_q <= S_OUT;
					unique case (act_q)
						idll_pkg::OP_PUSH_FRONT, idll_pkg::OP_PUSH_BACK,
						idll_pkg::OP_INSERT: begin
							count_q <= count_q + CW'(1);
							if (fresh_ok) begin
								fresh_q <= fresh_q + CW'(1);
							end else begin
								sp_q <= sp_q - CW'(1);
							end
							if (act_q == idll_pkg::OP_PUSH_FRONT) begin
								head_q <= n_new;
								if (count_q == '0) begin
									tail_q <= n_new;
								end
							end else if (act_q == idll_pkg::OP_PUSH_BACK) begin
								tail_q <= n_new;
								if (count_q == '0) begin
									head_q <= n_new;
								end
							end else begin
								n_q     <= n_new;
								p_q     <= prv_rd;
								state_q <= S_INS2;
							end
						end
						idll_pkg::OP_POP_FRONT, idll_pkg::OP_POP_BACK,
						idll_pkg::OP_ERASE: begin
							count_q    <= count_m1;
							sp_q       <= sp_q + CW'(1);
							res_data_q <= val_rd;
							if (act_q == idll_pkg::OP_POP_FRONT) begin
								head_q <= nxt_rd;
							end else if (act_q == idll_pkg::OP_POP_BACK) begin
								tail_q <= prv_rd;
							end
						end
						idll_pkg::OP_READ: begin
							res_data_q <= val_rd;
						end
						default: begin
						end
					endcase
				end
				S_INS2: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status_q;
			out_count_q  <= count_q;
			out_data_q   <= res_data_q;
		end
	end
endmodule
`default_nettype wire

// File: tb/list_scoreboard.sv
class list_scoreboard;
	logic [31:0] value [16];
	int          nxt [16];
	int          prv [16];
	int          head, tail, cnt;
	int          free_stk [16];
	int          free_top;
	logic [1:0]  exp_status [$];
	logic [4:0]  exp_count [$];
	logic [31:0] exp_data [$];
	int          errors;
	int          checked;

	function new();
		for (int i = 0; i < 16; i++) begin
			value[i] = '0;
			nxt[i] = 0;
			prv[i] = 0;
			free_stk[i] = 15 - i;
		end
		free_top = 16;
		head = 16;
		tail = 16;
		cnt = 0;
		errors = 0;
		checked = 0;
	endfunction

	function int take(logic [31:0] v);
		int n;
		free_top--;
		n = free_stk[free_top];
		value[n] = v;
		cnt++;
		return n;
	endfunction

	function void give(int n);
		free_stk[free_top] = n;
		free_top++;
		cnt--;
	endfunction

	function int node_at(int pos);
		int n;
		if (pos < cnt / 2) begin
			n = head;
			for (int i = 0; i < pos; i++) n = nxt[n];
		end else begin
			n = tail;
			for (int i = 0; i < cnt - 1 - pos; i++) n = prv[n];
		end
		return n;
	endfunction

	function void push_head(logic [31:0] v);
		int n;
		n = take(v);
		prv[n] = 16;
		nxt[n] = head;
		if (head < 16) prv[head] = n;
		else tail = n;
		head = n;
	endfunction

	function void push_tail(logic [31:0] v);
		int n;
		n = take(v);
		nxt[n] = 16;
		prv[n] = tail;
		if (tail < 16) nxt[tail] = n;
		else head = n;
		tail = n;
	endfunction

	function logic [31:0] pop_head();
		int n;
		n = head;
		head = nxt[n];
		if (head < 16) prv[head] = 16;
		else tail = 16;
		give(n);
		return value[n];
	endfunction

	function logic [31:0] pop_tail();
		int n;
		n = tail;
		tail = prv[n];
		if (tail < 16) nxt[tail] = 16;
		else head = 16;
		give(n);
		return value[n];
	endfunction

	function void note_request(logic [2:0] op, logic [4:0] pos, logic [31:0] d);
		logic [1:0]  st;
		logic [31:0] dout;
		int          n, p, q;
		st = idll_pkg::ST_OK;
		dout = '0;
		case (op)
			idll_pkg::OP_PUSH_FRONT: begin
				if (cnt >= 16) st = idll_pkg::ST_FULL;
				else push_head(d);
			end
			idll_pkg::OP_PUSH_BACK: begin
				if (cnt >= 16) st = idll_pkg::ST_FULL;
				else push_tail(d);
			end
			idll_pkg::OP_INSERT: begin
				if (pos > cnt) st = idll_pkg::ST_RANGE;
				else if (cnt >= 16) st = idll_pkg::ST_FULL;
				else if (pos == 0) push_head(d);
				else if (pos == cnt) push_tail(d);
				else begin
					q = node_at(pos);
					p = prv[q];
					n = take(d);
					nxt[n] = q;
					prv[n] = p;
					nxt[p] = n;
					prv[q] = n;
				end
			end
			idll_pkg::OP_POP_FRONT: begin
				if (cnt == 0) st = idll_pkg::ST_EMPTY;
				else dout = pop_head();
			end
			idll_pkg::OP_POP_BACK: begin
				if (cnt == 0) st = idll_pkg::ST_EMPTY;
				else dout = pop_tail();
			end
			default: begin
				if (cnt == 0) st = idll_pkg::ST_EMPTY;
				else if (pos >= cnt) st = idll_pkg::ST_RANGE;
				else if (op == idll_pkg::OP_ERASE) begin
					if (pos == 0) dout = pop_head();
					else if (pos == cnt - 1) dout = pop_tail();
					else begin
						n = node_at(pos);
						p = prv[n];
						q = nxt[n];
						dout = value[n];
						nxt[p] = q;
						prv[q] = p;
						give(n);
					end
				end else begin
					n = node_at(pos);
					if (op == idll_pkg::OP_READ) dout = value[n];
					else value[n] = d;
				end
			end
		endcase
		exp_status.insert(exp_status.size(), st);
		exp_count.insert(exp_count.size(), 5'(cnt));
		exp_data.insert(exp_data.size(), dout);
	endfunction

	function void check_response(logic [1:0] st, logic [4:0] c, logic [31:0] d);
		logic [1:0]  es;
		logic [4:0]  ec;
		logic [31:0] ed;
		if (exp_status.size() == 0) begin
			$error("unexpected response status=%0d count=%0d data=%h", st, c, d);
			errors++;
			return;
		end
		es = exp_status[0];
		ec = exp_count[0];
		ed = exp_data[0];
		exp_status.delete(0);
		exp_count.delete(0);
		exp_data.delete(0);
		checked++;
		if (st !== es) begin
			$error("status: expected %0d actual %0d", es, st);
			errors++;
		end
		if (c !== ec) begin
			$error("count: expected %0d actual %0d", ec, c);
			errors++;
		end
		if (d !== ed) begin
			$error("data_out: expected %h actual %h", ed, d);
			errors++;
		end
	endfunction
endclass

// File: tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	int   send_idle;
	int   recv_idle;
	bit   recv_hold;
	bit   hold_done;
	int   sent;

	idll_in_if  #(.POS_W(5), .DATA_W(32)) req ();
	idll_out_if #(.CNT_W(5), .DATA_W(32)) rsp ();

	indexed_doubly_linked_list dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	list_scoreboard list_model = new();

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready) list_model.note_request(req.opcode, req.position, req.data_in);
			if (rsp.valid && rsp.ready) list_model.check_response(rsp.status, rsp.count, rsp.data_out);
			rsp.ready <= !recv_hold && ($urandom_range(99) >= recv_idle);
		end
	end

	initial begin
		recv_hold = 1'b0;
		hold_done = 1'b0;
		wait (sent >= 700);
		@(posedge clk);
		recv_hold = 1'b1;
		repeat (300) @(posedge clk);
		recv_hold = 1'b0;
		hold_done = 1'b1;
	end

	task automatic send(logic [2:0] op, logic [4:0] pos, logic [31:0] d);
		while ($urandom_range(99) < send_idle) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.opcode <= op;
		req.position <= pos;
		req.data_in <= d;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		sent++;
	endtask

	task automatic send_random();
		int          r;
		logic [2:0]  op;
		logic [4:0]  pos;
		int          c;
		c = list_model.cnt;
		r = $urandom_range(99);
		op = 3'($urandom_range(7));
		if (c < 8 && r < 30) op = $urandom_range(1) ? idll_pkg::OP_PUSH_BACK : idll_pkg::OP_INSERT;
		if (c > 12 && r < 30) op = $urandom_range(1) ? idll_pkg::OP_ERASE : idll_pkg::OP_POP_FRONT;
		if (r >= 90) pos = 5'($urandom);
		else pos = 5'($urandom_range(c));
		send(op, pos, $urandom);
	endtask

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.opcode = '0;
		req.position = '0;
		req.data_in = '0;
		rsp.ready = 1'b0;
		sent = 0;
		send_idle = 0;
		recv_idle = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send(idll_pkg::OP_POP_FRONT, 0, 0);
		send(idll_pkg::OP_POP_BACK, 0, 0);
		send(idll_pkg::OP_ERASE, 0, 0);
		send(idll_pkg::OP_READ, 0, 0);
		send(idll_pkg::OP_WRITE, 0, 32'hffffffff);
		send(idll_pkg::OP_INSERT, 1, 1);
		send(idll_pkg::OP_INSERT, 0, 32'hffffffff);
		send(idll_pkg::OP_PUSH_BACK, 0, 32'h0);
		for (int i = 0; i < 14; i++) send(idll_pkg::OP_PUSH_FRONT, 5'(i), $urandom);
		send(idll_pkg::OP_INSERT, 8, 32'h5a5a5a5a);
		send(idll_pkg::OP_PUSH_BACK, 0, 1);
		send(idll_pkg::OP_INSERT, 16, 2);
		send(idll_pkg::OP_READ, 16, 0);
		send(idll_pkg::OP_ERASE, 31, 0);
		send(idll_pkg::OP_READ, 15, 0);
		send(idll_pkg::OP_ERASE, 7, 0);
		send(idll_pkg::OP_WRITE, 9, 32'hdeadbeef);
		send(idll_pkg::OP_READ, 9, 0);
		send_idle = 15;
		recv_idle = 45;
		for (int i = 0; i < 430; i++) send_random();
		send_idle = 45;
		recv_idle = 15;
		for (int i = 0; i < 430; i++) send_random();
		send_idle = 0;
		recv_idle = 0;
		for (int i = 0; i < 430; i++) send_random();
		req.valid <= 1'b0;
		wait (hold_done && list_model.exp_status.size() == 0);
		repeat (40) @(posedge clk);
		$display("Sent %0d list requests over all opcodes, checked %0d responses.",
			sent, list_model.checked);
		$display("Ran fill, drain, out-of-range and long back-pressure cases.");
		if (list_model.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

// File: filelist.f
design/idll_pkg.sv
design/idll_if.sv
design/idll_ram.sv
design/indexed_doubly_linked_list.sv
tb/list_scoreboard.sv
tb/testbench.sv
